[rtl/core/rls_pkg.sv]
// ----------------------------------------------------------------------------
// rls_pkg: shared types, constants and saturation helpers
// Fixed-point formats, configuration register codes, shared-unit request and
// response structs, and the saturation functions used by the estimator.
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int NUM_COEFS  = 4;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_IW    = $clog2(NUM_COEFS);
  localparam int COV_N      = NUM_COEFS * NUM_COEFS;
  localparam int COV_IW     = $clog2(COV_N);
  localparam int STEP_W     = COV_IW + 1;          // covers the 2*COV_N products pass
  localparam int WIDE_W     = 64;
  localparam int COV_W      = 48;
  localparam int EST_W      = 32;
  localparam int SH_W       = 5;
  localparam int LAM_W      = 17;
  localparam int THR_W      = 31;
  localparam int UPD_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int COV_DIV_SH = 16;                  // lambda is always Q1.16

  // lambda scaled to FRAC_BITS
  localparam int LAMQ_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int LAMQ_DN = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [COV_W-1:0]  cov_t;
  typedef logic signed [EST_W-1:0]  est_t;

  localparam wide_t WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam wide_t WIDE_MIN = 64'shC000_0000_0000_0000;
  localparam wide_t COV_HI   = (wide_t'(1) <<< (COV_W - 1)) - wide_t'(1);
  localparam wide_t COV_LO   = -COV_HI - wide_t'(1);
  localparam wide_t EST_HI   = (wide_t'(1) <<< (EST_W - 1)) - wide_t'(1);
  localparam wide_t EST_LO   = -EST_HI - wide_t'(1);
  localparam est_t  EST_ONE  = est_t'(1) <<< FRAC_BITS;

  localparam logic [LAM_W-1:0]   LAMBDA_ONE   = 17'd65536;
  localparam logic [LAM_W-1:0]   LAMBDA_RST   = 17'd64880;
  localparam logic [THR_W-1:0]   COV_INIT_RST = 31'd65536000;
  localparam logic [THR_W-1:0]   THRESH_RST   = 31'd1310720;
  localparam logic [UPD_W-1:0]   MIN_UPD_RST  = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORGET   = 2'd0,
    REG_COV_INIT = 2'd1,
    REG_THRESH   = 2'd2,
    REG_MIN_UPD  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic            start;
    logic            is_div;
    wide_t           a;
    wide_t           b;
    logic [SH_W-1:0] sh;
  } arith_req_t;

  typedef struct packed {
    logic  done;
    wide_t res;
  } arith_rsp_t;

  function automatic wide_t sat_wide(input logic signed [WIDE_W:0] x);
    wide_t r;
    if (x > (WIDE_W+1)'(WIDE_MAX)) r = WIDE_MAX;
    else if (x < (WIDE_W+1)'(WIDE_MIN)) r = WIDE_MIN;
    else r = x[WIDE_W-1:0];
    return r;
  endfunction

  function automatic wide_t adds(input wide_t a, input wide_t b);
    logic signed [WIDE_W:0] s;
    s = (WIDE_W+1)'(a) + (WIDE_W+1)'(b);
    return sat_wide(s);
  endfunction

  function automatic cov_t sat_cov(input wide_t x);
    cov_t r;
    if (x > COV_HI) r = COV_HI[COV_W-1:0];
    else if (x < COV_LO) r = COV_LO[COV_W-1:0];
    else r = x[COV_W-1:0];
    return r;
  endfunction

  function automatic est_t sat_est(input wide_t x);
    est_t r;
    if (x > EST_HI) r = EST_HI[EST_W-1:0];
    else if (x < EST_LO) r = EST_LO[EST_W-1:0];
    else r = x[EST_W-1:0];
    return r;
  endfunction

  // signed value from a magnitude, clipped to +-2^62
  function automatic wide_t signed_of(input logic [WIDE_W-1:0] m, input logic neg);
    wide_t r;
    if (neg) begin
      if (m > 64'h4000_0000_0000_0000) r = WIDE_MIN;
      else r = -$signed(m);
    end else begin
      if (m > 64'h3FFF_FFFF_FFFF_FFFF) r = WIDE_MAX;
      else r = $signed(m);
    end
    return r;
  endfunction

endpackage

[rtl/core/rls_arith.sv]
// ----------------------------------------------------------------------------
// rls_arith: shared multiply / divide unit
// Q-format multiply (4 partial products of 32x32, floored) and restoring
// divide (one quotient bit per cycle, truncated), both saturated to +-2^62.
// ----------------------------------------------------------------------------
module rls_arith import rls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } arith_state_t;

  localparam logic [6:0] DIV_STEPS = 7'd127;
  localparam logic [6:0] QBIT_TOP  = 7'd63;

  arith_state_t        state;
  logic                is_div;
  logic                neg;
  logic [WIDE_W-1:0]   ma;
  logic [WIDE_W-1:0]   mb;
  logic [6:0]          cnt;
  logic [WIDE_W-1:0]   pp;
  logic [6:0]          pp_sh;
  logic [2*WIDE_W-1:0] acc;
  logic [2*WIDE_W-1:0] num;
  logic [WIDE_W-1:0]   rem;
  logic [62:0]         quo;
  logic                over;
  logic                done;
  wide_t               res;

  logic [WIDE_W-1:0]   a_mag;
  logic [WIDE_W-1:0]   b_mag;
  logic [31:0]         op_a;
  logic [31:0]         op_b;
  logic [WIDE_W-1:0]   pp_cur;
  logic [6:0]          sh_cur;
  logic [WIDE_W-1:0]   r_sh;
  logic [WIDE_W-1:0]   q_mul;
  wide_t               fin_val;

  assign a_mag = req.a[WIDE_W-1] ? WIDE_W'(-req.a) : WIDE_W'(req.a);
  assign b_mag = req.b[WIDE_W-1] ? WIDE_W'(-req.b) : WIDE_W'(req.b);

  // one 32x32 multiplier, operand halves picked per step
  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        op_a   = ma[31:0];
        op_b   = mb[31:0];
        sh_cur = 7'd0;
      end
      2'd1: begin
        op_a   = ma[31:0];
        op_b   = mb[63:32];
        sh_cur = 7'd32;
      end
      2'd2: begin
        op_a   = ma[63:32];
        op_b   = mb[31:0];
        sh_cur = 7'd32;
      end
      default: begin
        op_a   = ma[63:32];
        op_b   = mb[63:32];
        sh_cur = 7'd64;
      end
    endcase
  end

  assign pp_cur = WIDE_W'(op_a) * WIDE_W'(op_b);

  assign r_sh  = {rem[WIDE_W-2:0], num[2*WIDE_W-1]};
  assign q_mul = acc[WIDE_W+FRAC_BITS-1:FRAC_BITS];

  always_comb begin
    if (is_div) begin
      fin_val = signed_of(over ? '1 : {1'b0, quo}, neg);
    end else if (|acc[2*WIDE_W-1:WIDE_W+FRAC_BITS]) begin
      fin_val = signed_of('1, neg);
    end else if (q_mul > 64'h4000_0000_0000_0001) begin
      fin_val = signed_of(q_mul, neg);
    end else begin
      fin_val = signed_of(q_mul + WIDE_W'(neg && (|acc[FRAC_BITS-1:0])), neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            is_div <= req.is_div;
            neg    <= req.a[WIDE_W-1] ^ (!req.is_div && req.b[WIDE_W-1]);
            ma     <= a_mag;
            mb     <= b_mag;
            acc    <= '0;
            rem    <= '0;
            quo    <= '0;
            over   <= 1'b0;
            num    <= {{WIDE_W{1'b0}}, a_mag} << req.sh;
            cnt    <= req.is_div ? DIV_STEPS : 7'd0;
            state  <= req.is_div ? A_DIV : A_MUL;
          end
        end
        A_MUL: begin
          pp    <= pp_cur;
          pp_sh <= sh_cur;
          if (cnt != 7'd0) acc <= acc + ({{WIDE_W{1'b0}}, pp} << pp_sh);
          if (cnt == 7'd4) state <= A_FIN;
          else cnt <= cnt + 7'd1;
        end
        A_DIV: begin
          num <= num << 1;
          if (r_sh >= mb) begin
            rem <= r_sh - mb;
            if (cnt >= QBIT_TOP) over <= 1'b1;
            else quo <= {quo[61:0], 1'b1};
          end else begin
            rem <= r_sh;
            if (cnt < QBIT_TOP) quo <= {quo[61:0], 1'b0};
          end
          if (cnt == 7'd0) state <= A_FIN;
          else cnt <= cnt - 7'd1;
        end
        A_FIN: begin
          res   <= fin_val;
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign rsp = '{done: done, res: res};

endmodule

[rtl/core/rls_arx_estimator_unit.sv]
// ----------------------------------------------------------------------------
// rls_arx_estimator_unit: RLS identification of a second-order ARX plant
// Q16.16 recursive least squares with exponential forgetting. A one-hot
// sequencer walks one shared multiply/divide unit through prediction,
// covariance products, gain, covariance and estimate updates.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                   | beat
//  sample   | in  | sample_valid / sample_stall | cmd, plant_output, plant_input, adapt_enable
//  result   | out | result_valid / result_stall | prediction_error, theta_*, adapting
//  cfg      | in  | cfg_we (no wait)            | cfg_index, cfg_data
//
//  A reinit beat goes straight to S_OUT, which writes its result and
//  frees the input in the same cycle. An update beat without adaptation
//  runs 4 multiplies, then error, history and output. An adapting update
//  runs 60 multiplies and 20 divides; the bit-serial divides (128 steps
//  each) take most of its time.
//  One beat is in work at a time; sample_stall is high from accept until
//  the result is written to the output register.
//  The output register holds a finished beat while the next sample is taken.
//  Reset (rst, synchronous) restores config defaults, theta=[1,0,0,0],
//  P=covariance_init*I, clears history and the update counter.
// ----------------------------------------------------------------------------
module rls_arx_estimator_unit import rls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // sample channel
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic                  cmd,
  input  logic signed [31:0]    plant_output,
  input  logic signed [31:0]    plant_input,
  input  logic                  adapt_enable,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic signed [31:0]    prediction_error,
  output logic signed [31:0]    theta_a1,
  output logic signed [31:0]    theta_a2,
  output logic signed [31:0]    theta_b0,
  output logic signed [31:0]    theta_b1,
  output logic                  adapting
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_PRED  = 12'b0000_0000_0010,
    S_ERR   = 12'b0000_0000_0100,
    S_VW    = 12'b0000_0000_1000,
    S_SUM   = 12'b0000_0001_0000,
    S_DEN   = 12'b0000_0010_0000,
    S_GAIN  = 12'b0000_0100_0000,
    S_PMUL  = 12'b0000_1000_0000,
    S_PDIV  = 12'b0001_0000_0000,
    S_THETA = 12'b0010_0000_0000,
    S_HIST  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } seq_state_t;

  // configuration registers
  logic [LAM_W-1:0] forget;
  logic [THR_W-1:0] cov_init;
  logic [THR_W-1:0] thresh;
  logic [UPD_W-1:0] min_upd;

  // estimator state
  est_t             est [NUM_COEFS];
  cov_t             cov [COV_N];
  est_t             y1, y2, u1;
  logic [UPD_W-1:0] upd_left;

  // per-beat working registers
  seq_state_t          state;
  logic [STEP_W-1:0]   idx;
  logic                busy;
  est_t                y_s, u_s;
  logic                en_s;
  logic signed [32:0]  phi [NUM_COEFS];
  wide_t               v [NUM_COEFS];
  wide_t               w [NUM_COEFS];
  wide_t               k [NUM_COEFS];
  wide_t               pred;
  wide_t               s_acc;
  wide_t               den;
  est_t                eps;
  cov_t                x_cov;
  logic                adapt_s;

  // shared unit
  arith_req_t req;
  arith_rsp_t rsp;

  logic [COEF_IW-1:0] ri, rj;
  logic [COV_IW-1:0]  cov_ri;
  logic [LAM_W-1:0]   lam;
  wide_t              lamq;
  wide_t              e_val;
  logic [WIDE_W-1:0]  e_mag;
  logic               trig;
  logic [UPD_W-1:0]   cnt_new;
  wide_t              den_val;
  logic               is_compute;
  logic               last4;
  logic               last16;

  assign ri     = idx[COV_IW-1:COEF_IW];
  assign rj     = idx[COEF_IW-1:0];
  // the w pass reads the transposed entry
  assign cov_ri = (state == S_VW && idx[COV_IW]) ? {rj, ri} : {ri, rj};
  assign last4  = (idx[COEF_IW-1:0] == '1);
  assign last16 = (idx[COV_IW-1:0] == '1);

  assign lam     = (forget != '0) ? forget : LAMBDA_ONE;
  assign lamq    = (wide_t'({1'b0, lam}) <<< LAMQ_UP) >>> LAMQ_DN;
  assign e_val   = wide_t'(y_s) - pred;
  assign e_mag   = e_val[WIDE_W-1] ? WIDE_W'(-e_val) : WIDE_W'(e_val);
  assign trig    = en_s && (e_mag > WIDE_W'(thresh));
  assign cnt_new = trig ? min_upd : upd_left;
  assign den_val = adds(s_acc, lamq);

  assign is_compute = (state == S_PRED) || (state == S_VW) || (state == S_SUM) ||
                      (state == S_GAIN) || (state == S_PMUL) || (state == S_PDIV) ||
                      (state == S_THETA);

  // operand select for the shared unit
  always_comb begin
    req.start  = is_compute && !busy;
    req.is_div = 1'b0;
    req.a      = '0;
    req.b      = '0;
    req.sh     = SH_W'(FRAC_BITS);
    case (state)
      S_PRED: begin
        req.a = wide_t'(phi[rj]);
        req.b = wide_t'(est[rj]);
      end
      S_VW: begin
        req.a = wide_t'(cov[cov_ri]);
        req.b = wide_t'(phi[rj]);
      end
      S_SUM: begin
        req.a = wide_t'(phi[rj]);
        req.b = v[rj];
      end
      S_GAIN: begin
        req.is_div = 1'b1;
        req.a      = v[rj];
        req.b      = den;
      end
      S_PMUL: begin
        req.a = k[ri];
        req.b = w[rj];
      end
      S_PDIV: begin
        req.is_div = 1'b1;
        req.a      = wide_t'(x_cov);
        req.b      = wide_t'({1'b0, lam});
        req.sh     = SH_W'(COV_DIV_SH);
      end
      S_THETA: begin
        req.a = k[rj];
        req.b = wide_t'(eps);
      end
      default: ;
    endcase
  end

  rls_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign sample_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      forget       <= LAMBDA_RST;
      cov_init     <= COV_INIT_RST;
      thresh       <= THRESH_RST;
      min_upd      <= MIN_UPD_RST;
      upd_left     <= '0;
      y1           <= '0;
      y2           <= '0;
      u1           <= '0;
      for (int i = 0; i < NUM_COEFS; i++) begin
        est[i] <= (i == 0) ? EST_ONE : '0;
      end
      for (int i = 0; i < COV_N; i++) begin
        cov[i] <= ((i / NUM_COEFS) == (i % NUM_COEFS)) ? cov_t'(COV_INIT_RST) : '0;
      end
      state        <= S_IDLE;
      idx          <= '0;
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_FORGET:   forget   <= cfg_data[LAM_W-1:0];
          REG_COV_INIT: cov_init <= cfg_data[THR_W-1:0];
          REG_THRESH:   thresh   <= cfg_data[THR_W-1:0];
          REG_MIN_UPD:  min_upd  <= cfg_data[UPD_W-1:0];
          default: ;
        endcase
      end

      if (result_valid && !result_stall) result_valid <= 1'b0;

      if (req.start) busy <= 1'b1;
      if (rsp.done)  busy <= 1'b0;

      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            idx <= '0;
            if (cmd) begin
              // reinit: counter is kept
              for (int i = 0; i < NUM_COEFS; i++) begin
                est[i] <= (i == 0) ? EST_ONE : '0;
              end
              for (int i = 0; i < COV_N; i++) begin
                cov[i] <= ((i / NUM_COEFS) == (i % NUM_COEFS)) ? cov_t'(cov_init) : '0;
              end
              y1      <= '0;
              y2      <= '0;
              u1      <= '0;
              eps     <= '0;
              adapt_s <= 1'b0;
              state   <= S_OUT;
            end else begin
              y_s     <= plant_output;
              u_s     <= plant_input;
              en_s    <= adapt_enable;
              phi[0]  <= -{y1[EST_W-1], y1};
              phi[1]  <= -{y2[EST_W-1], y2};
              phi[2]  <= {plant_input[EST_W-1], plant_input};
              phi[3]  <= {u1[EST_W-1], u1};
              pred    <= '0;
              adapt_s <= 1'b0;
              state   <= S_PRED;
            end
          end
        end
        S_PRED: begin
          if (rsp.done) begin
            pred <= pred + rsp.res;     // plain wrapping sum
            idx  <= idx + 1'b1;
            if (last4) state <= S_ERR;
          end
        end
        S_ERR: begin
          eps <= sat_est(e_val);
          idx <= '0;
          if (cnt_new != '0) begin
            upd_left <= cnt_new - 1'b1;
            for (int i = 0; i < NUM_COEFS; i++) begin
              v[i] <= '0;
              w[i] <= '0;
            end
            s_acc <= '0;
            state <= S_VW;
          end else begin
            upd_left <= cnt_new;
            state    <= S_HIST;
          end
        end
        S_VW: begin
          if (rsp.done) begin
            if (idx[COV_IW]) w[ri] <= adds(w[ri], rsp.res);
            else v[ri] <= adds(v[ri], rsp.res);
            idx <= idx + 1'b1;
            if (idx[COV_IW] && last16) begin
              idx   <= '0;
              state <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (rsp.done) begin
            s_acc <= adds(s_acc, rsp.res);
            idx   <= idx + 1'b1;
            if (last4) state <= S_DEN;
          end
        end
        S_DEN: begin
          den <= den_val;
          idx <= '0;
          // non-positive denominator: counter already spent, no update
          state <= (den_val > 0) ? S_GAIN : S_HIST;
        end
        S_GAIN: begin
          if (rsp.done) begin
            k[rj] <= rsp.res;
            idx   <= idx + 1'b1;
            if (last4) begin
              idx   <= '0;
              state <= S_PMUL;
            end
          end
        end
        S_PMUL: begin
          if (rsp.done) begin
            x_cov <= sat_cov(wide_t'(cov[idx[COV_IW-1:0]]) - rsp.res);
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (rsp.done) begin
            cov[idx[COV_IW-1:0]] <= sat_cov(rsp.res);
            idx                  <= idx + 1'b1;
            if (last16) begin
              idx   <= '0;
              state <= S_THETA;
            end else begin
              state <= S_PMUL;
            end
          end
        end
        S_THETA: begin
          if (rsp.done) begin
            est[rj] <= sat_est(wide_t'(est[rj]) + rsp.res);
            idx     <= idx + 1'b1;
            if (last4) begin
              adapt_s <= 1'b1;
              state   <= S_HIST;
            end
          end
        end
        S_HIST: begin
          y2    <= y1;
          y1    <= y_s;
          u1    <= u_s;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            prediction_error <= eps;
            theta_a1         <= est[0];
            theta_a2         <= est[1];
            theta_b0         <= est[2];
            theta_b1         <= est[3];
            adapting         <= adapt_s;
            result_valid     <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/rls_checker.sv]
// ----------------------------------------------------------------------------
// rls_checker: port-level checks for the RLS estimator
// Watches the sample and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module rls_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic        cmd,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] prediction_error,
  input logic        adapting
);

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!result_valid && !sample_stall))
    else $error("not idle after reset");

  // one beat in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("sample taken while busy");

  // reinit into a free output reports zero error and no adaptation
  a_reinit_result: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && cmd && !result_valid) |=>
      ##1 (result_valid && (prediction_error == 32'd0) && !adapting))
    else $error("reinit result wrong");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(prediction_error)))
    else $error("stalled result changed");

endmodule

bind rls_arx_estimator_unit rls_checker u_rls_checker (
  .clk              (clk),
  .rst              (rst),
  .sample_valid     (sample_valid),
  .sample_stall     (sample_stall),
  .cmd              (cmd),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .prediction_error (prediction_error),
  .adapting         (adapting)
);
